/* hw/rtl/uartmt_pkg.sv */
// Shared types and constants of the UART 8N1 message transceiver.
package uartmt_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_BIT_PERIOD    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_OFFSET = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_GAP      = 2'd2;

  localparam logic [15:0] BIT_PERIOD_RST    = 16'd1666;
  localparam logic [15:0] SAMPLE_OFFSET_RST = 16'd833;
  localparam logic [7:0]  IDLE_GAP_RST      = 8'd10;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_PUSH = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  localparam logic [3:0] DATA_BITS = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic       rx_level;
    logic [7:0] tx_byte;
    logic       tx_last;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       push_ok;
    logic       rx_dropped;
  } out_item_t;

endpackage

/* hw/rtl/uartmt_stream_if.sv */
// Valid/ready channel carrying one item.
interface uartmt_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/uartmt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module uartmt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hw/rtl/uart_8n1_message_transceiver.sv */
// UART 8N1 message transceiver. Every request on in_i is a timer tick (which
// advances both serial engines by one tick and samples rx_level), a push of one
// transmit byte, or a read of one received byte; each request yields exactly one
// result on out_o, in order. The block takes one request per clock while ready:
// all work of a request is done in the cycle it is accepted, and the result lands
// in an output register backed by a one-entry skid stage, so a stalled consumer
// costs nothing until both are full. Message bytes, message lengths and the
// receive FIFO live in three registered-read RAMs. Each RAM is read every cycle
// at the address the next state will need (head slot and byte index, head slot
// length, FIFO head), and a write that hits the address being read is forwarded,
// so the prefetched word is always current. No clearing pass follows reset.
module uart_8n1_message_transceiver #(
  parameter int TX_SLOTS      = 4,
  parameter int MAX_MSG_BYTES = 64,
  parameter int RX_DEPTH      = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  uartmt_stream_if.sink                 in_i,
  uartmt_stream_if.source               out_o,
  input  logic                          cfg_we_i,
  input  logic [uartmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [uartmt_pkg::CfgDataW-1:0] cfg_data_i
);
  import uartmt_pkg::*;

  localparam int SW      = $clog2(TX_SLOTS);
  localparam int LW      = $clog2(MAX_MSG_BYTES + 1);
  localparam int IW      = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int SBDepth = TX_SLOTS << IW;
  localparam int SBW     = SW + IW;
  localparam int PW      = $clog2(RX_DEPTH);

  // Configuration registers.
  logic [15:0] bit_period_q, sample_offset_q;
  logic [7:0]  idle_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q    <= BIT_PERIOD_RST;
      sample_offset_q <= SAMPLE_OFFSET_RST;
      idle_gap_q      <= IDLE_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIT_PERIOD:    bit_period_q    <= cfg_data_i;
        CFG_SAMPLE_OFFSET: sample_offset_q <= cfg_data_i;
        CFG_IDLE_GAP:      idle_gap_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Engine state.
  logic [1:0]    tx_phase_q, tx_phase_d;
  logic [15:0]   tx_timer_q, tx_timer_d;
  logic [7:0]    idle_cnt_q, idle_cnt_d;
  logic [7:0]    tx_shift_q, tx_shift_d;
  logic [3:0]    tx_cnt_q, tx_cnt_d;
  logic [LW-1:0] tx_idx_q, tx_idx_d;
  logic          tx_level_q, tx_level_d;
  logic [SW-1:0] slot_head_q, slot_head_d, slot_tail_q, slot_tail_d, slot_tail_nxt;
  logic [LW-1:0] fill_cnt_q, fill_cnt_d;
  logic          fill_rej_q, fill_rej_d;
  logic [1:0]    rx_phase_q, rx_phase_d;
  logic [15:0]   rx_timer_q, rx_timer_d;
  logic [7:0]    rx_shift_q, rx_shift_d;
  logic [3:0]    rx_cnt_q, rx_cnt_d;
  logic          rx_prev_q, rx_prev_d;
  logic [PW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d, rx_tail_nxt;

  // RAM ports and forwarding.
  logic           sb_we, sb_fwd_q;
  logic [SBW-1:0] sb_waddr, sb_raddr;
  logic [7:0]     sb_wdata, sb_rdata, sb_fwd_data_q, sb_val;
  logic           len_we, len_fwd_q;
  logic [SW-1:0]  len_waddr, len_raddr;
  logic [LW-1:0]  len_wdata, len_rdata, len_fwd_data_q, len_val;
  logic           ff_we, ff_fwd_q;
  logic [PW-1:0]  ff_waddr, ff_raddr;
  logic [7:0]     ff_wdata, ff_rdata, ff_fwd_data_q, ff_val;

  uartmt_ram #(.Width(8), .Depth(SBDepth)) u_slot_bytes (
    .clk_i, .we_i(sb_we), .waddr_i(sb_waddr), .wdata_i(sb_wdata),
    .raddr_i(sb_raddr), .rdata_o(sb_rdata)
  );
  uartmt_ram #(.Width(LW), .Depth(TX_SLOTS)) u_slot_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );
  uartmt_ram #(.Width(8), .Depth(RX_DEPTH)) u_rx_fifo (
    .clk_i, .we_i(ff_we), .waddr_i(ff_waddr), .wdata_i(ff_wdata),
    .raddr_i(ff_raddr), .rdata_o(ff_rdata)
  );

  assign sb_val  = sb_fwd_q  ? sb_fwd_data_q  : sb_rdata;
  assign len_val = len_fwd_q ? len_fwd_data_q : len_rdata;
  assign ff_val  = ff_fwd_q  ? ff_fwd_data_q  : ff_rdata;

  // Handshake and output buffering.
  out_item_t res, out_q, out_d, skid_q, skid_d;
  logic      out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic      acc, fire;
  in_item_t  item;

  assign item          = in_i.payload;
  assign in_i.ready    = !skid_vld_q;
  assign acc           = in_i.valid && !skid_vld_q;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;
  assign fire          = out_vld_q && out_o.ready;

  logic [16:0] tx_tsum, rx_tsum;
  logic        tx_fire, rx_fire, push_ok;
  logic [15:0] rx_target;

  assign tx_tsum       = {1'b0, tx_timer_q} + 17'd1;
  assign tx_fire       = tx_tsum >= {1'b0, bit_period_q};
  assign rx_target     = (rx_phase_q == PH_START) ? sample_offset_q : bit_period_q;
  assign rx_tsum       = {1'b0, rx_timer_q} + 17'd1;
  assign rx_fire       = rx_tsum >= {1'b0, rx_target};
  assign slot_tail_nxt = (slot_tail_q == SW'(TX_SLOTS - 1)) ? '0 : slot_tail_q + 1'b1;
  assign rx_tail_nxt   = (rx_tail_q == PW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
  assign push_ok       = !fill_rej_q && (slot_tail_nxt != slot_head_q)
                         && (fill_cnt_q < LW'(MAX_MSG_BYTES));

  always_comb begin
    tx_phase_d  = tx_phase_q;
    tx_timer_d  = tx_timer_q;
    idle_cnt_d  = idle_cnt_q;
    tx_shift_d  = tx_shift_q;
    tx_cnt_d    = tx_cnt_q;
    tx_idx_d    = tx_idx_q;
    tx_level_d  = tx_level_q;
    slot_head_d = slot_head_q;
    slot_tail_d = slot_tail_q;
    fill_cnt_d  = fill_cnt_q;
    fill_rej_d  = fill_rej_q;
    rx_phase_d  = rx_phase_q;
    rx_timer_d  = rx_timer_q;
    rx_shift_d  = rx_shift_q;
    rx_cnt_d    = rx_cnt_q;
    rx_prev_d   = rx_prev_q;
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    sb_we       = 1'b0;
    sb_waddr    = {slot_tail_q, fill_cnt_q[IW-1:0]};
    sb_wdata    = item.tx_byte;
    len_we      = 1'b0;
    len_waddr   = slot_tail_q;
    len_wdata   = fill_cnt_q + 1'b1;
    ff_we       = 1'b0;
    ff_waddr    = rx_tail_q;
    ff_wdata    = rx_shift_q;
    res         = '0;

    if (acc) begin
      unique case (item.func)
        FUNC_TICK: begin
          // Transmit bit clock.
          if (tx_fire) begin
            tx_timer_d = '0;
            unique case (tx_phase_q)
              PH_IDLE: begin
                if (idle_cnt_q < idle_gap_q) begin
                  idle_cnt_d = idle_cnt_q + 1'b1;
                end else if (slot_head_q != slot_tail_q) begin
                  tx_phase_d = PH_START;
                  tx_shift_d = sb_val;
                  tx_idx_d   = LW'(1);
                end
              end
              PH_START: begin
                tx_level_d = 1'b0;
                tx_phase_d = PH_DATA;
                tx_cnt_d   = '0;
              end
              PH_DATA: begin
                tx_level_d = tx_shift_q[0];
                tx_shift_d = {1'b0, tx_shift_q[7:1]};
                tx_cnt_d   = tx_cnt_q + 1'b1;
                if (tx_cnt_d >= DATA_BITS) begin
                  tx_phase_d = PH_STOP;
                end
              end
              default: begin
                tx_level_d = 1'b1;
                if (tx_idx_q < len_val) begin
                  tx_phase_d = PH_START;
                  tx_shift_d = sb_val;
                  tx_idx_d   = tx_idx_q + 1'b1;
                end else begin
                  tx_phase_d  = PH_IDLE;
                  idle_cnt_d  = '0;
                  slot_head_d = (slot_head_q == SW'(TX_SLOTS - 1)) ? '0
                                : slot_head_q + 1'b1;
                end
              end
            endcase
          end else begin
            tx_timer_d = tx_tsum[15:0];
          end

          // Receive sampler.
          if (rx_phase_q == PH_IDLE) begin
            if (rx_prev_q && !item.rx_level) begin
              rx_phase_d = PH_START;
              rx_timer_d = '0;
            end
          end else if (rx_fire) begin
            rx_timer_d = '0;
            unique case (rx_phase_q)
              PH_START: begin
                rx_phase_d = PH_DATA;
                rx_shift_d = '0;
                rx_cnt_d   = '0;
              end
              PH_DATA: begin
                rx_shift_d = {item.rx_level, rx_shift_q[7:1]};
                rx_cnt_d   = rx_cnt_q + 1'b1;
                if (rx_cnt_d >= DATA_BITS) begin
                  rx_phase_d = PH_STOP;
                end
              end
              default: begin
                // Stop bit: store the byte, or drop it when the FIFO is full.
                if (rx_tail_nxt != rx_head_q) begin
                  ff_we     = 1'b1;
                  rx_tail_d = rx_tail_nxt;
                end else begin
                  res.rx_dropped = 1'b1;
                end
                rx_phase_d = PH_IDLE;
              end
            endcase
          end else begin
            rx_timer_d = rx_tsum[15:0];
          end
          rx_prev_d = item.rx_level;
        end
        FUNC_PUSH: begin
          if (push_ok) begin
            sb_we       = 1'b1;
            fill_cnt_d  = fill_cnt_q + 1'b1;
            res.push_ok = 1'b1;
          end else begin
            fill_rej_d = 1'b1;
          end
          if (item.tx_last) begin
            // Commit the slot only if the whole message fit.
            if (push_ok) begin
              len_we      = 1'b1;
              slot_tail_d = slot_tail_nxt;
            end
            fill_cnt_d = '0;
            fill_rej_d = 1'b0;
          end
        end
        FUNC_READ: begin
          if (rx_head_q != rx_tail_q) begin
            res.rx_data  = ff_val;
            res.rx_valid = 1'b1;
            rx_head_d    = (rx_head_q == PW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.tx_line = tx_level_d;
  end

  // Prefetch next-state addresses; the idle transmitter needs byte zero.
  assign sb_raddr  = {slot_head_d, (tx_phase_d == PH_IDLE) ? IW'(0) : tx_idx_d[IW-1:0]};
  assign len_raddr = slot_head_d;
  assign ff_raddr  = rx_head_d;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (fire) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    if (acc) begin
      if (!out_vld_d) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q          <= out_d;
    skid_q         <= skid_d;
    sb_fwd_data_q  <= sb_wdata;
    len_fwd_data_q <= len_wdata;
    ff_fwd_data_q  <= ff_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
      sb_fwd_q    <= 1'b0;
      len_fwd_q   <= 1'b0;
      ff_fwd_q    <= 1'b0;
      tx_phase_q  <= PH_IDLE;
      tx_timer_q  <= '0;
      idle_cnt_q  <= '0;
      tx_shift_q  <= '0;
      tx_cnt_q    <= '0;
      tx_idx_q    <= '0;
      tx_level_q  <= 1'b1;
      slot_head_q <= '0;
      slot_tail_q <= '0;
      fill_cnt_q  <= '0;
      fill_rej_q  <= 1'b0;
      rx_phase_q  <= PH_IDLE;
      rx_timer_q  <= '0;
      rx_shift_q  <= '0;
      rx_cnt_q    <= '0;
      rx_prev_q   <= 1'b1;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
    end else begin
      out_vld_q   <= out_vld_d;
      skid_vld_q  <= skid_vld_d;
      sb_fwd_q    <= sb_we && (sb_waddr == sb_raddr);
      len_fwd_q   <= len_we && (len_waddr == len_raddr);
      ff_fwd_q    <= ff_we && (ff_waddr == ff_raddr);
      tx_phase_q  <= tx_phase_d;
      tx_timer_q  <= tx_timer_d;
      idle_cnt_q  <= idle_cnt_d;
      tx_shift_q  <= tx_shift_d;
      tx_cnt_q    <= tx_cnt_d;
      tx_idx_q    <= tx_idx_d;
      tx_level_q  <= tx_level_d;
      slot_head_q <= slot_head_d;
      slot_tail_q <= slot_tail_d;
      fill_cnt_q  <= fill_cnt_d;
      fill_rej_q  <= fill_rej_d;
      rx_phase_q  <= rx_phase_d;
      rx_timer_q  <= rx_timer_d;
      rx_shift_q  <= rx_shift_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_prev_q   <= rx_prev_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
    end
  end
endmodule

/* tb/testbench.sv */
// Self-checking testbench of the UART 8N1 message transceiver.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uartmt_pkg::*;

  localparam int SLOTS   = 4;
  localparam int MSG_MAX = 64;
  localparam int FIFO_D  = 64;
  localparam int STALL_LIMIT = 2000;
  // Function code with no defined action; the block reports the line level only.
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  uartmt_stream_if #(.item_t(in_item_t)) in_if ();
  uartmt_stream_if #(.item_t(out_item_t)) out_if ();

  uart_8n1_message_transceiver DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Behavioral copy of the transceiver: register shadow plus both serial engines.
  // ---------------------------------------------------------------------------
  logic [15:0] bit_ticks, first_sample;
  logic [7:0]  gap_bits;

  logic [1:0]  tx_ph;
  logic [15:0] tx_tmr;
  logic [7:0]  gap_cnt;
  logic [7:0]  tx_sr;
  logic [3:0]  tx_nbits;
  logic [6:0]  tx_idx;
  logic        tx_lvl;
  logic [7:0]  msg_mem [SLOTS*MSG_MAX];
  logic [6:0]  msg_len [SLOTS];
  logic [1:0]  slot_rd, slot_wr;
  logic [6:0]  fill_n;
  logic        fill_bad;

  logic [1:0]  rx_ph;
  logic [15:0] rx_tmr;
  logic [7:0]  rx_sr;
  logic [3:0]  rx_nbits;
  logic        rx_last_lvl;
  logic [7:0]  rx_mem [FIFO_D];
  logic [5:0]  rx_rd, rx_wr;

  function automatic void uart_model_reset();
    bit_ticks = BIT_PERIOD_RST;
    first_sample = SAMPLE_OFFSET_RST;
    gap_bits = IDLE_GAP_RST;
    tx_ph = PH_IDLE; tx_tmr = '0; gap_cnt = '0; tx_sr = '0; tx_nbits = '0;
    tx_idx = '0; tx_lvl = 1'b1; slot_rd = '0; slot_wr = '0; fill_n = '0;
    fill_bad = 1'b0;
    rx_ph = PH_IDLE; rx_tmr = '0; rx_sr = '0; rx_nbits = '0; rx_last_lvl = 1'b1;
    rx_rd = '0; rx_wr = '0;
  endfunction

  // One serial bit time of the transmitter.
  function automatic void tx_bit_time();
    case (tx_ph)
      PH_IDLE: begin
        if (gap_cnt < gap_bits) begin
          gap_cnt++;
        end else if (slot_rd != slot_wr) begin
          tx_ph = PH_START;
          tx_sr = msg_mem[slot_rd*MSG_MAX];
          tx_idx = 7'd1;
        end
      end
      PH_START: begin
        tx_lvl = 1'b0;
        tx_ph = PH_DATA;
        tx_nbits = '0;
      end
      PH_DATA: begin
        tx_lvl = tx_sr[0];
        tx_sr = tx_sr >> 1;
        tx_nbits++;
        if (tx_nbits >= DATA_BITS) tx_ph = PH_STOP;
      end
      default: begin
        tx_lvl = 1'b1;
        if (tx_idx < msg_len[slot_rd]) begin
          tx_ph = PH_START;
          tx_sr = msg_mem[slot_rd*MSG_MAX + tx_idx];
          tx_idx++;
        end else begin
          tx_ph = PH_IDLE;
          gap_cnt = '0;
          slot_rd++;
        end
      end
    endcase
  endfunction

  // Receiver sample point; returns 1 when the finished byte finds the FIFO full.
  function automatic logic rx_sample(logic lvl);
    logic lost;
    lost = 1'b0;
    if (rx_ph == PH_START) begin
      rx_ph = PH_DATA;
      rx_sr = '0;
      rx_nbits = '0;
    end else if (rx_ph == PH_DATA) begin
      rx_sr = {lvl, rx_sr[7:1]};
      rx_nbits++;
      if (rx_nbits >= DATA_BITS) rx_ph = PH_STOP;
    end else begin
      if (rx_wr + 6'd1 != rx_rd) begin
        rx_mem[rx_wr] = rx_sr;
        rx_wr++;
      end else begin
        lost = 1'b1;
      end
      rx_ph = PH_IDLE;
    end
    return lost;
  endfunction

  function automatic logic timer_tick(logic lvl);
    logic lost;
    logic [15:0] target;
    lost = 1'b0;
    tx_tmr++;
    if (tx_tmr >= bit_ticks) begin
      tx_tmr = '0;
      tx_bit_time();
    end
    if (rx_ph == PH_IDLE) begin
      if (rx_last_lvl && !lvl) begin
        rx_ph = PH_START;
        rx_tmr = '0;
      end
    end else begin
      target = (rx_ph == PH_START) ? first_sample : bit_ticks;
      rx_tmr++;
      if (rx_tmr >= target) begin
        rx_tmr = '0;
        lost = rx_sample(lvl);
      end
    end
    rx_last_lvl = lvl;
    return lost;
  endfunction

  function automatic logic slot_push(logic [7:0] b, logic last);
    logic ok;
    ok = 1'b0;
    if (!fill_bad && slot_wr + 2'd1 != slot_rd && fill_n < MSG_MAX) begin
      msg_mem[slot_wr*MSG_MAX + fill_n] = b;
      fill_n++;
      ok = 1'b1;
    end else begin
      fill_bad = 1'b1;
    end
    if (last) begin
      if (ok) begin
        msg_len[slot_wr] = fill_n;
        slot_wr++;
      end
      fill_n = '0;
      fill_bad = 1'b0;
    end
    return ok;
  endfunction

  function automatic out_item_t uart_predict(in_item_t req);
    out_item_t r;
    r = '0;
    case (req.func)
      FUNC_TICK: r.rx_dropped = timer_tick(req.rx_level);
      FUNC_PUSH: r.push_ok = slot_push(req.tx_byte, req.tx_last);
      FUNC_READ: begin
        if (rx_rd != rx_wr) begin
          r.rx_data = rx_mem[rx_rd];
          r.rx_valid = 1'b1;
          rx_rd++;
        end
      end
      default: ;
    endcase
    r.tx_line = tx_lvl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver, result checker and watchdog.
  // ---------------------------------------------------------------------------
  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int n_reqs, n_results, n_errors, n_bytes_read, n_pushed, n_drops;
  int src_mode, sink_mode, src_wait, sink_wait, quiet_cycles;

  // Mode 0 runs without gaps; mode 1 rarely pauses; mode 2 pauses freely.
  function automatic int draw_wait(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 0;
    return $urandom_range(0, 14);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic free;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      src_wait = 0;
      src_mode = 0;
    end else begin
      free = !in_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(uart_predict(in_if.payload));
        n_reqs++;
        free = 1'b1;
        if ($urandom_range(0, 99) == 0) src_mode = $urandom_range(0, 2);
      end
      // Hold the request until taken; otherwise wait out the drawn gap, then send.
      if (free) begin
        if (src_wait > 0) begin
          src_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.payload <= pending_reqs.pop_front();
          src_wait = draw_wait(src_mode);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_wait = 0;
      sink_mode = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got 0x%0h", $time, got);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("tx_line", want.tx_line, got.tx_line);
          check_field("rx_data", want.rx_data, got.rx_data);
          check_field("rx_valid", want.rx_valid, got.rx_valid);
          check_field("push_ok", want.push_ok, got.push_ok);
          check_field("rx_dropped", want.rx_dropped, got.rx_dropped);
          n_bytes_read += want.rx_valid;
          n_pushed += want.push_ok;
          n_drops += want.rx_dropped;
        end
        if ($urandom_range(0, 99) == 0) sink_mode = $urandom_range(0, 2);
        sink_wait = draw_wait(sink_mode);
      end
      // Drop ready for the drawn stall, then raise it again.
      if (sink_wait > 0) begin
        sink_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers: every helper appends requests to the pending queue.
  // ---------------------------------------------------------------------------
  function automatic void add_req(logic [1:0] f, logic lvl, logic [7:0] b, logic last);
    in_item_t r;
    r.func = f; r.rx_level = lvl; r.tx_byte = b; r.tx_last = last;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_ticks(logic lvl, int n);
    for (int i = 0; i < n; i++) add_req(FUNC_TICK, lvl, 8'($urandom), 1'($urandom));
  endfunction

  function automatic void add_reads(int n);
    for (int i = 0; i < n; i++) add_req(FUNC_READ, 1'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  // Serial frame on the receive line at the current bit time; cut marks a broken frame.
  function automatic void add_frame(logic [7:0] b, int cut);
    int p;
    p = (bit_ticks == 0) ? 1 : bit_ticks;
    add_ticks(1'b0, p);
    for (int i = 0; i < 8 && i < cut; i++) add_ticks(b[i], p);
    add_ticks(1'b1, p + $urandom_range(0, p));
  endfunction

  function automatic void add_message(int len);
    for (int i = 0; i < len; i++) add_req(FUNC_PUSH, 1'($urandom), 8'($urandom), i == len - 1);
  endfunction

  // Mixed traffic, mostly well-formed frames and messages.
  function automatic void add_mix(int n);
    int goal;
    goal = pending_reqs.size() + n;
    while (pending_reqs.size() < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_frame(8'($urandom), 8);
        4, 5: add_message(($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                        : $urandom_range(1, 6));
        6: add_reads($urandom_range(1, 4));
        7: add_ticks(1'b1, $urandom_range(1, 30));
        8: begin
          for (int i = 0; i < 4; i++) begin
            add_req(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), 1'($urandom));
          end
        end
        default: add_frame(8'($urandom), $urandom_range(0, 7));
      endcase
    end
  endfunction

  // Let all queued requests through and every result come back.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_if.valid) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_BIT_PERIOD: bit_ticks = val;
      CFG_SAMPLE_OFFSET: first_sample = val;
      default: gap_bits = val[7:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cfg(logic [15:0] bp, logic [15:0] so, logic [7:0] gap);
    drain();
    write_cfg(CFG_BIT_PERIOD, bp);
    write_cfg(CFG_SAMPLE_OFFSET, so);
    write_cfg(CFG_IDLE_GAP, {8'd0, gap});
  endtask

  initial begin
    uart_model_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, empty read, unused code, byte extremes in the ring.
    add_reads(1);
    add_req(FUNC_NONE, 1'b1, 8'hFF, 1'b1);
    add_req(FUNC_PUSH, 1'b0, 8'h00, 1'b0);
    add_req(FUNC_PUSH, 1'b1, 8'hFF, 1'b1);
    add_ticks(1'b1, 3);
    set_cfg(16'd1, 16'd0, 8'd0);

    // Full ring: the last messages are refused; oversized message is discarded.
    add_message(1); add_message(2); add_message(1); add_message(1);
    add_frame(8'h00, 8);
    add_frame(8'hFF, 8);
    // Falling edge inside a frame must not restart reception.
    add_ticks(1'b1, 2); add_ticks(1'b0, 1); add_ticks(1'b1, 1); add_ticks(1'b0, 1);
    add_ticks(1'b1, 20);
    add_reads(3);
    add_ticks(1'b1, 60);
    add_message(65);
    add_message(3);
    add_ticks(1'b1, 60);

    // Zero bit period acts as one tick.
    set_cfg(16'd0, 16'd1, 8'd3);
    add_mix(150);

    // Gap lowered while the idle count is above it.
    set_cfg(16'd1, 16'd1, 8'd255);
    add_message(2);
    add_ticks(1'b1, 100);
    set_cfg(16'd1, 16'd1, 8'd5);
    add_ticks(1'b1, 40);

    // Fill the receive FIFO past full, then empty it.
    set_cfg(16'd1, 16'd0, 8'd0);
    for (int i = 0; i < 66; i++) add_frame(8'($urandom), 8);
    add_reads(66);

    // Largest settings: nothing reaches a bit boundary.
    set_cfg(16'hFFFF, 16'hFFFF, 8'hFF);
    add_message(2);
    add_ticks(1'b0, 20);
    add_ticks(1'b1, 20);

    // Random phases at small bit times; each change waits for an idle block.
    for (int ph = 0; ph < 6; ph++) begin
      int bp;
      bp = $urandom_range(1, 4);
      set_cfg(16'(bp), 16'($urandom_range(0, bp)), 8'($urandom_range(0, 4)));
      add_mix(60);
    end
    drain();

    $display("Checked %0d results of %0d requests: %0d bytes read, %0d pushes taken,",
             n_results, n_reqs, n_bytes_read, n_pushed);
    $display("%0d receive drops, over thirteen register settings.", n_drops);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/uartmt_pkg.sv
hw/rtl/uartmt_stream_if.sv
hw/rtl/uartmt_ram.sv
hw/rtl/uart_8n1_message_transceiver.sv
tb/testbench.sv
